/* hw/rtl/vfa_pkg.sv */
`default_nettype none

package vfa_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int ROOT_STAGES = DATA_W;
    localparam int DIV_STAGES  = DATA_W + FRAC_BITS;

    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_SUB   = 3'd1;
    localparam logic [2:0] CMD_MUL   = 3'd2;
    localparam logic [2:0] CMD_DIV   = 3'd3;
    localparam logic [2:0] CMD_CROSS = 3'd4;
    localparam logic [2:0] CMD_DOT   = 3'd5;
    localparam logic [2:0] CMD_NORM  = 3'd6;
    localparam logic [2:0] CMD_UNIT  = 3'd7;

    localparam logic [DATA_W-1:0] QMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] QMIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic signed [67:0] WIDE_MAX = 68'sh7fffffff;
    localparam logic signed [67:0] WIDE_MIN = ~WIDE_MAX;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              ovf;
    } sat_t;

    // front end results, carried alongside the root pipeline
    typedef struct packed {
        logic [2:0]              cmd;
        logic [2:0][DATA_W-1:0]  r;
        logic [DATA_W-1:0]       s;
        logic                    fault;
        logic [2:0][DATA_W-1:0]  amag;
        logic [2:0]              aneg;
        logic [2:0][DATA_W-1:0]  bmag;
        logic [2:0]              bneg;
        logic [63:0]             sq;
    } front_t;

    // carried alongside the divider lanes
    typedef struct packed {
        logic [2:0]              cmd;
        logic [2:0][DATA_W-1:0]  r;
        logic [DATA_W-1:0]       s;
        logic                    fault;
        logic [2:0]              aneg;
        logic [2:0]              bneg;
        logic [2:0]              azero;
        logic [2:0]              dzero;
    } lane_t;

    function automatic sat_t sat32(input logic signed [67:0] v);
        sat_t res;
        res.val = v[DATA_W-1:0];
        res.ovf = 1'b0;
        if (v > WIDE_MAX) begin
            res.val = QMAX;
            res.ovf = 1'b1;
        end else if (v < WIDE_MIN) begin
            res.val = QMIN;
            res.ovf = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    // apply sign to an unsigned quotient; big marks bits lost above the top
    function automatic sat_t quo_sat(input logic [DATA_W-1:0] q, input logic big,
                                     input logic neg);
        sat_t res;
        if (neg) begin
            res.ovf = big | (q[DATA_W-1] & (|q[DATA_W-2:0]));
            res.val = res.ovf ? QMIN : (~q + 1'b1);
        end else begin
            res.ovf = big | q[DATA_W-1];
            res.val = res.ovf ? QMAX : q;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/vfa_front.sv */
`default_nettype none

module vfa_front
    import vfa_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic [2:0]             cmd,
    input  wire logic                   use_scalar,
    input  wire logic [2:0][DATA_W-1:0] a,
    input  wire logic [2:0][DATA_W-1:0] b,
    input  wire logic [DATA_W-1:0]      scalar_in,
    output logic                        out_valid,
    output front_t                      out_f
);

    // stage 1: operand capture
    logic                   v1_reg;
    logic [2:0]             cmd1_reg;
    logic [2:0][DATA_W-1:0] a1_reg, b1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        cmd1_reg <= cmd;
        a1_reg   <= a;
        if (use_scalar && cmd < CMD_CROSS)
            b1_reg <= {3{scalar_in}};
        else
            b1_reg <= b;
    end

    // stage 2: products, add/sub
    logic                   v2_reg;
    front_t                 f2_reg, f2_next;
    logic signed [63:0]     p2_reg [0:5];
    logic signed [63:0]     p_next [0:5];

    always_comb
    begin
        logic signed [32:0] sum;
        logic [DATA_W-1:0]  opnd;
        sat_t               st;
        f2_next       = '0;
        f2_next.cmd   = cmd1_reg;
        for (int i = 0; i < 3; i++) begin
            f2_next.amag[i] = mag32(a1_reg[i]);
            f2_next.aneg[i] = a1_reg[i][DATA_W-1];
            f2_next.bmag[i] = mag32(b1_reg[i]);
            f2_next.bneg[i] = b1_reg[i][DATA_W-1];
            if (cmd1_reg == CMD_SUB)
                sum = $signed({a1_reg[i][DATA_W-1], a1_reg[i]})
                    - $signed({b1_reg[i][DATA_W-1], b1_reg[i]});
            else
                sum = $signed({a1_reg[i][DATA_W-1], a1_reg[i]})
                    + $signed({b1_reg[i][DATA_W-1], b1_reg[i]});
            st = sat32(68'(sum));
            if (cmd1_reg == CMD_ADD || cmd1_reg == CMD_SUB) begin
                f2_next.r[i]  = st.val;
                f2_next.fault = f2_next.fault | st.ovf;
            end
            opnd = (cmd1_reg == CMD_NORM || cmd1_reg == CMD_UNIT) ? a1_reg[i] : b1_reg[i];
            if (cmd1_reg == CMD_CROSS)
                p_next[i] = $signed(a1_reg[(i+1)%3]) * $signed(b1_reg[(i+2)%3]);
            else
                p_next[i] = $signed(a1_reg[i]) * $signed(opnd);
            p_next[i+3] = $signed(a1_reg[(i+2)%3]) * $signed(b1_reg[(i+1)%3]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        f2_reg <= f2_next;
        for (int i = 0; i < 6; i++)
            p2_reg[i] <= p_next[i];
    end

    // stage 3: mul and cross finish, partial dot / square sum
    logic                   v3_reg;
    front_t                 f3_reg, f3_next;
    logic signed [65:0]     sum01_reg, sum01_next;
    logic signed [63:0]     p3_reg;

    always_comb
    begin
        logic signed [64:0] d;
        sat_t               st;
        f3_next    = f2_reg;
        sum01_next = 66'(p2_reg[0]) + 66'(p2_reg[1]);
        for (int i = 0; i < 3; i++) begin
            d = 65'(p2_reg[i]) - 65'(p2_reg[i+3]);
            if (f2_reg.cmd == CMD_CROSS)
                st = sat32(68'(d >>> FRAC_BITS));
            else
                st = sat32(68'(p2_reg[i] >>> FRAC_BITS));
            if (f2_reg.cmd == CMD_MUL || f2_reg.cmd == CMD_CROSS) begin
                f3_next.r[i]  = st.val;
                f3_next.fault = f3_next.fault | st.ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        f3_reg    <= f3_next;
        sum01_reg <= sum01_next;
        p3_reg    <= p2_reg[2];
    end

    // stage 4: dot product and square sum
    logic   v4_reg;
    front_t f4_reg, f4_next;

    always_comb
    begin
        logic signed [65:0] total;
        sat_t               st;
        f4_next = f3_reg;
        total   = sum01_reg + 66'(p3_reg);
        st      = sat32(68'(total >>> FRAC_BITS));
        f4_next.sq = total[63:0];
        if (f3_reg.cmd == CMD_DOT) begin
            f4_next.s     = st.val;
            f4_next.fault = st.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        f4_reg <= f4_next;
    end

    assign out_valid = v4_reg;
    assign out_f     = f4_reg;

endmodule

`default_nettype wire

/* hw/rtl/vfa_sqrt.sv */
`default_nettype none

module vfa_sqrt
    import vfa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire front_t            in_f,
    output logic                   out_valid,
    output logic [DATA_W-1:0]      out_root,
    output front_t                 out_f
);

    localparam int REM_W = DATA_W + 2;

    logic              v_reg    [0:ROOT_STAGES-1];
    logic [REM_W-1:0]  rem_reg  [0:ROOT_STAGES-1];
    logic [DATA_W-1:0] root_reg [0:ROOT_STAGES-1];
    logic [63:0]       n_reg    [0:ROOT_STAGES-1];
    front_t            f_reg    [0:ROOT_STAGES-1];

    logic              v_in    [0:ROOT_STAGES-1];
    logic [REM_W-1:0]  rem_in  [0:ROOT_STAGES-1];
    logic [DATA_W-1:0] root_in [0:ROOT_STAGES-1];
    logic [63:0]       n_in    [0:ROOT_STAGES-1];
    front_t            f_in    [0:ROOT_STAGES-1];

    // one root bit per stage, two radicand bits brought down each time
    for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
        logic [REM_W+1:0] trial, tsub;
        logic             ge;

        if (k == 0) begin : g_first
            assign v_in[k]    = in_valid;
            assign rem_in[k]  = '0;
            assign root_in[k] = '0;
            assign n_in[k]    = in_f.sq;
            assign f_in[k]    = in_f;
        end else begin : g_next
            assign v_in[k]    = v_reg[k-1];
            assign rem_in[k]  = rem_reg[k-1];
            assign root_in[k] = root_reg[k-1];
            assign n_in[k]    = n_reg[k-1];
            assign f_in[k]    = f_reg[k-1];
        end

        assign trial = {rem_in[k], n_in[k][63:62]};
        assign tsub  = {2'b00, root_in[k], 2'b01};
        assign ge    = (trial >= tsub);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else
                v_reg[k] <= v_in[k];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= ge ? REM_W'(trial - tsub) : REM_W'(trial);
            root_reg[k] <= {root_in[k][DATA_W-2:0], ge};
            n_reg[k]    <= {n_in[k][61:0], 2'b00};
            f_reg[k]    <= f_in[k];
        end
    end

    assign out_valid = v_reg[ROOT_STAGES-1];
    assign out_root  = root_reg[ROOT_STAGES-1];
    assign out_f     = f_reg[ROOT_STAGES-1];

endmodule

`default_nettype wire

/* hw/rtl/vfa_div.sv */
`default_nettype none

module vfa_div
    import vfa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [DATA_W-1:0] num,
    input  wire logic [DATA_W-1:0] den,
    output logic [DATA_W-1:0]      quo,
    output logic                   big
);

    logic [DATA_W-1:0]     rem_reg [0:DIV_STAGES-1];
    logic [DATA_W-1:0]     den_reg [0:DIV_STAGES-1];
    logic [DIV_STAGES-1:0] dd_reg  [0:DIV_STAGES-1];
    logic [DATA_W-1:0]     q_reg   [0:DIV_STAGES-1];
    logic                  big_reg [0:DIV_STAGES-1];

    logic [DATA_W-1:0]     rem_in [0:DIV_STAGES-1];
    logic [DATA_W-1:0]     den_in [0:DIV_STAGES-1];
    logic [DIV_STAGES-1:0] dd_in  [0:DIV_STAGES-1];
    logic [DATA_W-1:0]     q_in   [0:DIV_STAGES-1];
    logic                  big_in [0:DIV_STAGES-1];

    // restoring division, one quotient bit per stage; only the low word is
    // kept, anything shifted out above it is remembered in big
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DATA_W:0] trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign rem_in[k] = '0;
            assign den_in[k] = den;
            assign dd_in[k]  = {num, {FRAC_BITS{1'b0}}};
            assign q_in[k]   = '0;
            assign big_in[k] = 1'b0;
        end else begin : g_next
            assign rem_in[k] = rem_reg[k-1];
            assign den_in[k] = den_reg[k-1];
            assign dd_in[k]  = dd_reg[k-1];
            assign q_in[k]   = q_reg[k-1];
            assign big_in[k] = big_reg[k-1];
        end

        assign trial = {rem_in[k], dd_in[k][DIV_STAGES-1]};
        assign ge    = (trial >= {1'b0, den_in[k]});

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? DATA_W'(trial - {1'b0, den_in[k]}) : DATA_W'(trial);
            den_reg[k] <= den_in[k];
            dd_reg[k]  <= {dd_in[k][DIV_STAGES-2:0], 1'b0};
            q_reg[k]   <= {q_in[k][DATA_W-2:0], ge};
            big_reg[k] <= big_in[k] | q_in[k][DATA_W-1];
        end
    end

    assign quo = q_reg[DIV_STAGES-1];
    assign big = big_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

/* hw/rtl/vector3_fixed_point_alu_unit.sv */
`default_nettype none
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------------
// request  | start, busy          | cmd, use_scalar, ax ay az, bx by_comp bz, scalar_in
// result   | done (1-cycle strobe)| rx ry rz, scalar_out, fault
//
// One request per cycle is taken; busy never rises.
// done pulses once a request has passed four front stages (operand, multiply, two adds),
// one stage per root bit, one stage per quotient bit of the divider lanes, and the output
// register; the data are Q15.16.
// Results leave in request order; nothing is held back since the receiver cannot stall.
// Reset clears only the valid bits of the pipeline.

module vector3_fixed_point_alu_unit
    import vfa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        cmd,
    input  wire logic              use_scalar,
    input  wire logic [DATA_W-1:0] ax,
    input  wire logic [DATA_W-1:0] ay,
    input  wire logic [DATA_W-1:0] az,
    input  wire logic [DATA_W-1:0] bx,
    input  wire logic [DATA_W-1:0] by_comp,
    input  wire logic [DATA_W-1:0] bz,
    input  wire logic [DATA_W-1:0] scalar_in,
    output logic                   done,
    output logic [DATA_W-1:0]      rx,
    output logic [DATA_W-1:0]      ry,
    output logic [DATA_W-1:0]      rz,
    output logic [DATA_W-1:0]      scalar_out,
    output logic                   fault
);

    assign busy = 1'b0;

    logic   fr_valid;
    front_t fr_f;

    vfa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .cmd        (cmd),
        .use_scalar (use_scalar),
        .a          ({az, ay, ax}),
        .b          ({bz, by_comp, bx}),
        .scalar_in  (scalar_in),
        .out_valid  (fr_valid),
        .out_f      (fr_f)
    );

    logic              sq_valid;
    logic [DATA_W-1:0] root;
    front_t            sq_f;

    vfa_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_f      (fr_f),
        .out_valid (sq_valid),
        .out_root  (root),
        .out_f     (sq_f)
    );

    // divisor is |b| for divide, the norm for unit vector
    logic [2:0][DATA_W-1:0] den;
    lane_t                  mid;

    always_comb
    begin
        mid       = '0;
        mid.cmd   = sq_f.cmd;
        mid.r     = sq_f.r;
        mid.s     = sq_f.s;
        mid.fault = sq_f.fault;
        mid.aneg  = sq_f.aneg;
        mid.bneg  = sq_f.bneg;
        for (int i = 0; i < 3; i++) begin
            den[i]       = (sq_f.cmd == CMD_UNIT) ? root : sq_f.bmag[i];
            mid.azero[i] = (sq_f.amag[i] == '0);
            mid.dzero[i] = (den[i] == '0);
        end
        if (sq_f.cmd == CMD_NORM) begin
            mid.s     = root[DATA_W-1] ? QMAX : root;
            mid.fault = root[DATA_W-1];
        end
    end

    logic [2:0][DATA_W-1:0] quo;
    logic [2:0]             big;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        vfa_div u_div (
            .clk (clk),
            .num (sq_f.amag[i]),
            .den (den[i]),
            .quo (quo[i]),
            .big (big[i])
        );
    end

    logic  vd_reg [0:DIV_STAGES-1];
    lane_t ld_reg [0:DIV_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++)
                vd_reg[k] <= 1'b0;
        end else begin
            vd_reg[0] <= sq_valid;
            for (int k = 1; k < DIV_STAGES; k++)
                vd_reg[k] <= vd_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        ld_reg[0] <= mid;
        for (int k = 1; k < DIV_STAGES; k++)
            ld_reg[k] <= ld_reg[k-1];
    end

    // final selection
    lane_t                  fin;
    logic [2:0][DATA_W-1:0] r_next;
    logic                   f_next;

    assign fin = ld_reg[DIV_STAGES-1];

    always_comb
    begin
        sat_t st;
        r_next = fin.r;
        f_next = fin.fault;
        for (int i = 0; i < 3; i++) begin
            case (fin.cmd)
                CMD_DIV:
                begin
                    if (fin.dzero[i]) begin
                        f_next    = 1'b1;
                        r_next[i] = fin.azero[i] ? '0 : (fin.aneg[i] ? QMIN : QMAX);
                    end else begin
                        st        = quo_sat(quo[i], big[i], fin.aneg[i] ^ fin.bneg[i]);
                        r_next[i] = st.val;
                        f_next    = f_next | st.ovf;
                    end
                end
                CMD_UNIT:
                begin
                    if (fin.dzero[i]) begin
                        r_next[i] = '0;
                    end else begin
                        st        = quo_sat(quo[i], big[i], fin.aneg[i]);
                        r_next[i] = st.val;
                        f_next    = f_next | st.ovf;
                    end
                end
                default:
                begin
                    r_next[i] = fin.r[i];
                end
            endcase
        end
    end

    logic                   done_reg;
    logic [2:0][DATA_W-1:0] r_reg;
    logic [DATA_W-1:0]      s_reg;
    logic                   fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vd_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        s_reg     <= fin.s;
        fault_reg <= f_next;
    end

    assign done       = done_reg;
    assign rx         = r_reg[0];
    assign ry         = r_reg[1];
    assign rz         = r_reg[2];
    assign scalar_out = s_reg;
    assign fault      = fault_reg;

endmodule

`default_nettype wire

/* bench/vector3_alu_checker.sv */
module vector3_alu_checker
    import vfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [2:0]        cmd,
    input  logic              use_scalar,
    input  logic [DATA_W-1:0] ax,
    input  logic [DATA_W-1:0] ay,
    input  logic [DATA_W-1:0] az,
    input  logic [DATA_W-1:0] bx,
    input  logic [DATA_W-1:0] by_comp,
    input  logic [DATA_W-1:0] bz,
    input  logic [DATA_W-1:0] scalar_in,
    input  logic              done,
    input  logic [DATA_W-1:0] rx,
    input  logic [DATA_W-1:0] ry,
    input  logic [DATA_W-1:0] rz,
    input  logic [DATA_W-1:0] scalar_out,
    input  logic              fault,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
        logic [DATA_W-1:0] s;
        logic              f;
    } vec_result_t;

    vec_result_t alu_results_q[$];
    int          err_cnt = 0;

    assign fail_count = err_cnt;
    assign pending    = alu_results_q.size();

    localparam logic signed [127:0] LIM_HI = 128'sd2147483647;
    localparam logic signed [127:0] LIM_LO = -128'sd2147483648;

    function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic f);
        if (v > LIM_HI) begin
            f = 1'b1;
            return QMAX;
        end
        if (v < LIM_LO) begin
            f = 1'b1;
            return QMIN;
        end
        return v[31:0];
    endfunction

    // arithmetic shift gives floor division by 2^FRAC_BITS
    function automatic logic signed [127:0] floor_q(input logic signed [127:0] p);
        return p >>> FRAC_BITS;
    endfunction

    function automatic logic signed [127:0] trunc_quot(input logic signed [127:0] n,
                                                      input logic signed [127:0] d);
        logic signed [127:0] mn, md, q;
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        q  = (mn <<< FRAC_BITS) / md;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic logic [127:0] floor_sqrt(input logic [127:0] n);
        logic [127:0] r, b;
        r = 0;
        for (int i = 40; i >= 0; i--) begin
            b = r | (128'd1 << i);
            if (b * b <= n) r = b;
        end
        return r;
    endfunction

    function automatic vec_result_t compute_alu(
        input logic [2:0] op, input logic bc,
        input logic [2:0][31:0] av, input logic [2:0][31:0] bv, input logic [31:0] sv);
        logic signed [127:0] a[3], b[3], t;
        logic [127:0] sq, m;
        logic [31:0] r[3];
        vec_result_t res;
        logic f;
        f = 1'b0;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            a[i] = $signed(av[i]);
            b[i] = (bc && op < CMD_CROSS) ? $signed(sv) : $signed(bv[i]);
            r[i] = '0;
        end
        case (op)
            CMD_ADD: for (int i = 0; i < 3; i++) r[i] = clamp(a[i] + b[i], f);
            CMD_SUB: for (int i = 0; i < 3; i++) r[i] = clamp(a[i] - b[i], f);
            CMD_MUL: for (int i = 0; i < 3; i++) r[i] = clamp(floor_q(a[i] * b[i]), f);
            CMD_DIV:
                for (int i = 0; i < 3; i++) begin
                    if (b[i] == 0) begin
                        f = 1'b1;
                        r[i] = (a[i] > 0) ? QMAX : ((a[i] < 0) ? QMIN : '0);
                    end else
                        r[i] = clamp(trunc_quot(a[i], b[i]), f);
                end
            CMD_CROSS: begin
                r[0] = clamp(floor_q(a[1] * b[2] - a[2] * b[1]), f);
                r[1] = clamp(floor_q(a[2] * b[0] - a[0] * b[2]), f);
                r[2] = clamp(floor_q(a[0] * b[1] - a[1] * b[0]), f);
            end
            CMD_DOT: begin
                t = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
                res.s = clamp(floor_q(t), f);
            end
            default: begin
                sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
                m = floor_sqrt(sq);
                if (op == CMD_NORM)
                    res.s = clamp($signed(m), f);
                else if (m != 0)
                    for (int i = 0; i < 3; i++)
                        r[i] = clamp(trunc_quot(a[i], $signed(m)), f);
            end
        endcase
        res.x = r[0];
        res.y = r[1];
        res.z = r[2];
        res.f = f;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
        err_cnt++;
    endtask

    always @(posedge clk) begin
        vec_result_t want;
        if (rst_n && start && !busy)
            alu_results_q.push_back(compute_alu(cmd, use_scalar, {az, ay, ax},
                                                {bz, by_comp, bx}, scalar_in));
        if (rst_n && done) begin
            if (alu_results_q.size() == 0) begin
                $display("%0t: result with no request outstanding", $realtime);
                err_cnt++;
            end else begin
                want = alu_results_q.pop_front();
                if (rx !== want.x) report_mismatch("rx", rx, want.x);
                if (ry !== want.y) report_mismatch("ry", ry, want.y);
                if (rz !== want.z) report_mismatch("rz", rz, want.z);
                if (scalar_out !== want.s) report_mismatch("scalar_out", scalar_out, want.s);
                if (fault !== want.f) report_mismatch("fault", fault, want.f);
            end
        end
    end
endmodule

/* bench/vector3_fixed_point_alu_unit_tb.sv */
module vector3_fixed_point_alu_unit_tb;
    import vfa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy, done, fault;
    logic [2:0] cmd = CMD_ADD;
    logic use_scalar = 1'b0;
    logic [DATA_W-1:0] ax = '0, ay = '0, az = '0, bx = '0, by_comp = '0, bz = '0;
    logic [DATA_W-1:0] scalar_in = '0;
    logic [DATA_W-1:0] rx, ry, rz, scalar_out;
    int fail_count, pending;

    vector3_fixed_point_alu_unit u_top (.*);

    vector3_alu_checker u_chk (.*);

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #2ms;
        $display("vector3_fixed_point_alu_unit test failed");
        $finish;
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return QMAX;
            1: return QMIN;
            2: return '0;
            3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
            4: return $urandom_range(0, 3);
            5: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
            6: return $signed($urandom_range(0, 32'h1ff_ffff)) - 32'sh100_0000;
            default: return $urandom;
        endcase
    endfunction

    // hold one request until the block takes it
    task automatic send(input logic [2:0] op, input logic bc,
                        input logic [31:0] a0, a1, a2, b0, b1, b2, sv);
        start <= 1'b1;
        cmd <= op;
        use_scalar <= bc;
        ax <= a0; ay <= a1; az <= a2;
        bx <= b0; by_comp <= b1; bz <= b2;
        scalar_in <= sv;
        do @(posedge clk); while (busy);
    endtask

    initial begin
        logic [31:0] v[7];
        bit calm;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: every op, extremes, zero divisors, zero-length unit
        for (int op = 0; op < 8; op++) begin
            send(3'(op), 1'b0, QMAX, QMIN, 32'h0001_8000, QMAX, QMAX, '0, 32'h0002_0000);
            send(3'(op), 1'b1, QMIN, '0, 32'hfffe_8000, 32'h0003_0000, QMIN, QMAX, QMIN);
        end
        send(CMD_DIV, 1'b1, 32'h0001_0000, 32'hffff_0000, '0, '0, '0, '0, '0);
        send(CMD_DIV, 1'b0, 32'h0005_0000, '0, 32'h7, 32'h0002_0000, 32'h1, '0, '0);
        send(CMD_UNIT, 1'b0, '0, '0, '0, QMAX, QMAX, QMAX, QMAX);
        send(CMD_UNIT, 1'b0, 32'h1, '0, '0, '0, '0, '0, '0);
        send(CMD_NORM, 1'b1, QMIN, QMIN, QMIN, '0, '0, '0, '0);
        send(CMD_UNIT, 1'b0, QMIN, QMAX, 32'h3, '0, '0, '0, '0);
        send(CMD_DOT, 1'b0, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, '0);
        send(CMD_CROSS, 1'b0, 32'hffff_ffff, 32'h1, 32'h2, 32'h3, 32'hffff_fffe, 32'h5, '0);
        for (int n = 0; n < 950; n++) begin
            calm = (n >= 400 && n < 550);
            // outside the calm stretch, each cycle idles with a 33 in 100 chance
            while (!calm && $urandom_range(0, 99) < 33) begin
                start <= 1'b0;
                @(posedge clk);
            end
            foreach (v[i]) v[i] = pick_value();
            send(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                 v[0], v[1], v[2], v[3], v[4], v[5], v[6]);
        end
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("vector3_fixed_point_alu_unit test passed");
        else
            $display("vector3_fixed_point_alu_unit test failed");
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/vfa_pkg.sv
hw/rtl/vfa_front.sv
hw/rtl/vfa_sqrt.sv
hw/rtl/vfa_div.sv
hw/rtl/vector3_fixed_point_alu_unit.sv
bench/vector3_alu_checker.sv
bench/vector3_fixed_point_alu_unit_tb.sv
